// ===== hw/rtl/retreat_point_from_danger_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the retreat point block
// Short forms for clocked, reset-qualified property checks.
// ----------------------------------------------------------------------------
`ifndef RETREAT_POINT_FROM_DANGER_MACROS_SVH
`define RETREAT_POINT_FROM_DANGER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define RPFD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("retreat_point_from_danger: check failed");

// Next-cycle implication, disabled while reset is held.
`define RPFD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("retreat_point_from_danger: check failed");

`endif

// ===== hw/rtl/rpfd_pkg.sv =====
// ----------------------------------------------------------------------------
// rpfd_pkg
// Shared constants, register indexes and control types of the retreat block.
// ----------------------------------------------------------------------------
package rpfd_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_IDX_W      = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAP_WIDTH   = 2'd0,
        REG_MAP_HEIGHT  = 2'd1,
        REG_EDGE_MARGIN = 2'd2,
        REG_PLAYER_ONE  = 2'd3
    } t_reg_idx;

    localparam logic [CFG_DATA_W-1:0] RST_MAP_WIDTH   = 16'hFFFF;
    localparam logic [CFG_DATA_W-1:0] RST_MAP_HEIGHT  = 16'hFFFF;
    localparam logic [CFG_DATA_W-1:0] RST_EDGE_MARGIN = 16'h0000;
    localparam logic                  RST_PLAYER_ONE  = 1'b1;

    // Control of one serial arithmetic unit: load operands, then step.
    typedef struct packed {
        logic load;
        logic step;
    } t_unit_ctl;

endpackage

// ===== hw/rtl/rpfd_mul.sv =====
// ----------------------------------------------------------------------------
// rpfd_mul
// Bit-serial shift-add multiplier, one multiplier bit per step.
// ----------------------------------------------------------------------------
module rpfd_mul
    import rpfd_pkg::*;
#(
    parameter int W = COORD_BITS_DEF
) (
    input  logic           i_clk,
    input  t_unit_ctl      i_ctl,
    input  logic [W-1:0]   i_a,
    input  logic [W-1:0]   i_b,
    output logic [2*W-1:0] o_prod
);

    logic [W-1:0] r_mcand;
    logic [W-1:0] r_hi;
    logic [W-1:0] r_lo;
    logic [W:0]   w_sum;

    // The low half starts as the multiplier and fills with product bits
    // as it shifts right.
    assign w_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mcand} : '0);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_mcand <= i_a;
            r_hi    <= '0;
            r_lo    <= i_b;
        end else if (i_ctl.step) begin
            r_hi <= w_sum[W:1];
            r_lo <= {w_sum[0], r_lo[W-1:1]};
        end
    end

    assign o_prod = {r_hi, r_lo};

endmodule

// ===== hw/rtl/rpfd_isqrt.sv =====
// ----------------------------------------------------------------------------
// rpfd_isqrt
// Bit-pair restoring integer square root, one root bit per step.
// ----------------------------------------------------------------------------
module rpfd_isqrt
    import rpfd_pkg::*;
#(
    parameter int W = COORD_BITS_DEF
) (
    input  logic           i_clk,
    input  t_unit_ctl      i_ctl,
    input  logic [2*W+1:0] i_val,
    output logic [W:0]     o_root
);

    logic [2*W+1:0] r_val;
    logic [W+1:0]   r_rem;
    logic [W:0]     r_root;
    logic [W+3:0]   w_rem_sh;
    logic [W+3:0]   w_trial;
    logic [W+3:0]   w_diff;
    logic           w_ge;

    // Bring down the next pair of radicand bits and try root*4 + 1.
    assign w_rem_sh = {r_rem, r_val[2*W+1:2*W]};
    assign w_trial  = {1'b0, r_root, 2'b01};
    assign w_ge     = (w_rem_sh >= w_trial);
    assign w_diff   = w_rem_sh - w_trial;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_val  <= i_val;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_ctl.step) begin
            r_val  <= {r_val[2*W-1:0], 2'b00};
            r_rem  <= w_ge ? w_diff[W+1:0] : w_rem_sh[W+1:0];
            r_root <= {r_root[W-1:0], w_ge};
        end
    end

    assign o_root = r_root;

endmodule

// ===== hw/rtl/rpfd_div.sv =====
// ----------------------------------------------------------------------------
// rpfd_div
// Restoring divider, one quotient bit per step, for quotients below 2^W.
// ----------------------------------------------------------------------------
module rpfd_div
    import rpfd_pkg::*;
#(
    parameter int W = COORD_BITS_DEF
) (
    input  logic           i_clk,
    input  t_unit_ctl      i_ctl,
    input  logic [2*W-1:0] i_num,
    input  logic [W:0]     i_den,
    output logic [W-1:0]   o_quot
);

    logic [W:0]   r_rem;
    logic [W-1:0] r_lo;
    logic [W+1:0] w_trial;
    logic [W+1:0] w_diff;
    logic         w_ge;

    // The upper half of the dividend is already below the divisor, so only
    // the low W bits produce quotient bits.
    assign w_trial = {r_rem, r_lo[W-1]};
    assign w_ge    = (w_trial >= {1'b0, i_den});
    assign w_diff  = w_trial - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rem <= {1'b0, i_num[2*W-1:W]};
            r_lo  <= i_num[W-1:0];
        end else if (i_ctl.step) begin
            r_rem <= w_ge ? w_diff[W:0] : w_trial[W:0];
            r_lo  <= {r_lo[W-2:0], w_ge};
        end
    end

    assign o_quot = r_lo;

endmodule

// ===== hw/rtl/retreat_point_from_danger.sv =====
// ----------------------------------------------------------------------------
// retreat_point_from_danger
// Moves a point a given distance straight away from a danger point and
// clamps the result to the map less its edge margin.
// ----------------------------------------------------------------------------
// One item is in flight at a time; a new beat is taken only in the idle
// state. The work is three serial passes run back to back: a shift-add
// pass that forms dx*dx, dy*dy, |dx|*distance and |dy|*distance together,
// a bit-pair square root that gives the vector length, and a restoring
// divide for both axes at once, with a state each to sum the squares,
// pick the divisor and clamp. The clamp state holds while the output
// register is still full. The division truncates toward zero. When both
// points coincide the move goes along -x if player_one is set and along
// +x otherwise. A finished result sits in an output register, so a new
// beat is taken while it waits to be read. Configuration writes are
// registered and must only be made while no item is in flight.
// ----------------------------------------------------------------------------
`include "retreat_point_from_danger_macros.svh"

module retreat_point_from_danger
    import rpfd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Input beats.
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // origin_x, origin_y, danger_x, danger_y, step_distance (lowest first)
    input  logic [((5*COORD_BITS+7)/8)*8-1:0]     i_s_tdata,
    // Result beats.
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // away_x, away_y (lowest first)
    output logic [((2*COORD_BITS+7)/8)*8-1:0]     o_m_tdata,
    // Register writes.
    input  logic                                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]                 i_cfg_data
);

    localparam int W          = COORD_BITS;
    localparam int OUT_DATA_W = ((2*W+7)/8)*8;
    localparam int CNT_W      = $clog2(W+2);
    localparam int CW         = W+2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_SQRT,
        S_FIX,
        S_DIV,
        S_CLAMP
    } t_state;

    // Configuration registers.
    logic [CFG_DATA_W-1:0] r_map_width;
    logic [CFG_DATA_W-1:0] r_map_height;
    logic [CFG_DATA_W-1:0] r_edge_margin;
    logic                  r_player_one;

    // Sequencer and result registers.
    t_state         r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic           r_out_valid, n_out_valid;
    logic [W-1:0]   r_away_x, n_away_x;
    logic [W-1:0]   r_away_y, n_away_y;

    // Per-item operands kept for the whole computation.
    logic [W-1:0]   r_ox;
    logic [W-1:0]   r_oy;
    logic [W-1:0]   r_dist;
    logic           r_neg_x;
    logic           r_neg_y;
    logic [W:0]     r_len;

    // Input fields and the difference vector.
    logic [W-1:0]   w_in_ox, w_in_oy, w_in_px, w_in_py, w_in_dist;
    logic [W:0]     w_dx, w_dy, w_neg_dx, w_neg_dy;
    logic [W-1:0]   w_abs_x, w_abs_y;
    logic           w_accept;

    // Arithmetic unit connections.
    t_unit_ctl      w_mul_ctl, w_sqrt_ctl, w_div_ctl;
    logic [2*W-1:0] w_prod_xx, w_prod_yy, w_prod_xd, w_prod_yd;
    logic [2*W:0]   w_sq;
    logic [W:0]     w_root;
    logic           w_zero_len;
    logic [2*W-1:0] w_num_x, w_num_y;
    logic [W:0]     w_den;
    logic [W-1:0]   w_quot_x, w_quot_y;

    // Clamp bounds, taken at coordinate width.
    logic [W-1:0]   w_margin_m, w_width_m, w_height_m;
    logic [W-1:0]   w_clamp_x, w_clamp_y;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_width   <= RST_MAP_WIDTH;
            r_map_height  <= RST_MAP_HEIGHT;
            r_edge_margin <= RST_EDGE_MARGIN;
            r_player_one  <= RST_PLAYER_ONE;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_MAP_WIDTH:   r_map_width   <= i_cfg_data;
                REG_MAP_HEIGHT:  r_map_height  <= i_cfg_data;
                REG_EDGE_MARGIN: r_edge_margin <= i_cfg_data;
                REG_PLAYER_ONE:  r_player_one  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // The registers are 16 bits wide; the clamp sees them at the
    // coordinate width, dropping upper bits on narrow builds.
    generate
        if (W >= CFG_DATA_W) begin : g_cfg_wide
            assign w_margin_m = W'(r_edge_margin);
            assign w_width_m  = W'(r_map_width);
            assign w_height_m = W'(r_map_height);
        end else begin : g_cfg_narrow
            assign w_margin_m = r_edge_margin[W-1:0];
            assign w_width_m  = r_map_width[W-1:0];
            assign w_height_m = r_map_height[W-1:0];
        end
    endgenerate

    // ------------------------------------------------------------------
    // Input unpacking and the difference vector
    // ------------------------------------------------------------------
    assign w_in_ox   = i_s_tdata[W-1:0];
    assign w_in_oy   = i_s_tdata[2*W-1:W];
    assign w_in_px   = i_s_tdata[3*W-1:2*W];
    assign w_in_py   = i_s_tdata[4*W-1:3*W];
    assign w_in_dist = i_s_tdata[5*W-1:4*W];

    assign w_dx     = {1'b0, w_in_ox} - {1'b0, w_in_px};
    assign w_dy     = {1'b0, w_in_oy} - {1'b0, w_in_py};
    assign w_neg_dx = -w_dx;
    assign w_neg_dy = -w_dy;
    // Magnitudes are at most 2^W - 1, so W bits hold them.
    assign w_abs_x  = w_dx[W] ? w_neg_dx[W-1:0] : w_dx[W-1:0];
    assign w_abs_y  = w_dy[W] ? w_neg_dy[W-1:0] : w_dy[W-1:0];

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    // ------------------------------------------------------------------
    // Serial arithmetic
    // ------------------------------------------------------------------
    assign w_mul_ctl.load  = w_accept;
    assign w_mul_ctl.step  = (r_state == S_MUL);
    assign w_sqrt_ctl.load = (r_state == S_SUM);
    assign w_sqrt_ctl.step = (r_state == S_SQRT);
    assign w_div_ctl.load  = (r_state == S_FIX);
    assign w_div_ctl.step  = (r_state == S_DIV);

    // The four products share one pass over the multiplier bits.
    rpfd_mul #(.W(W)) u_mul_xx (
        .i_clk  (i_clk),
        .i_ctl  (w_mul_ctl),
        .i_a    (w_abs_x),
        .i_b    (w_abs_x),
        .o_prod (w_prod_xx)
    );

    rpfd_mul #(.W(W)) u_mul_yy (
        .i_clk  (i_clk),
        .i_ctl  (w_mul_ctl),
        .i_a    (w_abs_y),
        .i_b    (w_abs_y),
        .o_prod (w_prod_yy)
    );

    rpfd_mul #(.W(W)) u_mul_xd (
        .i_clk  (i_clk),
        .i_ctl  (w_mul_ctl),
        .i_a    (w_abs_x),
        .i_b    (w_in_dist),
        .o_prod (w_prod_xd)
    );

    rpfd_mul #(.W(W)) u_mul_yd (
        .i_clk  (i_clk),
        .i_ctl  (w_mul_ctl),
        .i_a    (w_abs_y),
        .i_b    (w_in_dist),
        .o_prod (w_prod_yd)
    );

    // The squared length is below 2^(2W+1); the root fits in W+1 bits.
    assign w_sq = {1'b0, w_prod_xx} + {1'b0, w_prod_yy};

    rpfd_isqrt #(.W(W)) u_isqrt (
        .i_clk  (i_clk),
        .i_ctl  (w_sqrt_ctl),
        .i_val  ({1'b0, w_sq}),
        .o_root (w_root)
    );

    // Coincident points: divide the full distance by one along x only.
    assign w_zero_len = (w_root == '0);
    assign w_num_x    = w_zero_len ? {{W{1'b0}}, r_dist} : w_prod_xd;
    assign w_num_y    = w_zero_len ? '0 : w_prod_yd;
    assign w_den      = w_zero_len ? (W+1)'(1) : w_root;

    // Each quotient is at most the step distance, since the length is at
    // least as large as either component.
    rpfd_div #(.W(W)) u_div_x (
        .i_clk  (i_clk),
        .i_ctl  (w_div_ctl),
        .i_num  (w_num_x),
        .i_den  (r_len),
        .o_quot (w_quot_x)
    );

    rpfd_div #(.W(W)) u_div_y (
        .i_clk  (i_clk),
        .i_ctl  (w_div_ctl),
        .i_num  (w_num_y),
        .i_den  (r_len),
        .o_quot (w_quot_y)
    );

    // ------------------------------------------------------------------
    // Clamp
    // ------------------------------------------------------------------
    // The moved position lies in -(2^W - 1) .. 2^(W+1) - 2, so W+2 signed
    // bits carry it without overflow.
    function automatic logic [W-1:0] clamp_axis(
        input logic [W-1:0] origin,
        input logic [W-1:0] quot,
        input logic         neg,
        input logic [W-1:0] size,
        input logic [W-1:0] margin
    );
        logic signed [CW-1:0] pos;
        logic signed [CW-1:0] lo;
        logic signed [CW-1:0] hi;
        logic signed [CW-1:0] res;
        pos = neg ? $signed({2'b00, origin}) - $signed({2'b00, quot})
                  : $signed({2'b00, origin}) + $signed({2'b00, quot});
        lo  = $signed({2'b00, margin});
        hi  = $signed({2'b00, size}) - lo;
        if (hi < lo) begin
            hi = lo;
        end
        res = pos;
        if (res < lo) begin
            res = lo;
        end
        if (res > hi) begin
            res = hi;
        end
        return res[W-1:0];
    endfunction

    assign w_clamp_x = clamp_axis(r_ox, w_quot_x, r_neg_x, w_width_m, w_margin_m);
    assign w_clamp_y = clamp_axis(r_oy, w_quot_y, r_neg_y, w_height_m, w_margin_m);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        n_away_x    = r_away_x;
        n_away_y    = r_away_y;

        // The waiting result leaves when the sink takes it.
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_MUL;
                    n_cnt   = '0;
                end
            end
            S_MUL: begin
                if (r_cnt == CNT_W'(W-1)) begin
                    n_state = S_SUM;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SUM: begin
                n_state = S_SQRT;
            end
            S_SQRT: begin
                if (r_cnt == CNT_W'(W)) begin
                    n_state = S_FIX;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FIX: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_cnt == CNT_W'(W-1)) begin
                    n_state = S_CLAMP;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_CLAMP: begin
                // Hold here until the output register is free.
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_away_x    = w_clamp_x;
                    n_away_y    = w_clamp_y;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_away_x <= n_away_x;
        r_away_y <= n_away_y;
    end

    // Operand capture; the fallback direction replaces the x sign when
    // the length comes out zero.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ox    <= w_in_ox;
            r_oy    <= w_in_oy;
            r_dist  <= w_in_dist;
            r_neg_x <= w_dx[W];
            r_neg_y <= w_dy[W];
        end
        if (r_state == S_FIX) begin
            r_len <= w_den;
            if (w_zero_len) begin
                r_neg_x <= r_player_one;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DATA_W'({r_away_y, r_away_x});

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `RPFD_ASSERT_NXT(a_accept_starts_mul, i_clk, i_rst_n, w_accept, r_state == S_MUL)
    `RPFD_ASSERT_IMP(a_div_den_nonzero, i_clk, i_rst_n, r_state == S_DIV, r_len != '0)
    `RPFD_ASSERT_IMP(a_quot_within_step, i_clk, i_rst_n, r_state == S_CLAMP, (w_quot_x <= r_dist) && (w_quot_y <= r_dist))
    `RPFD_ASSERT_NXT(a_clamp_waits, i_clk, i_rst_n, (r_state == S_CLAMP) && r_out_valid && !i_m_tready, r_state == S_CLAMP)

endmodule

// ===== tb/retreat_point_from_danger_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// retreat_point_from_danger_tb
// Drives input beats, writes registers while the block is idle, and checks
// every result beat against a retreat point typed in the table or predicted in the bench.
// ----------------------------------------------------------------------------
// A short directed table runs first. It covers coincident points under both
// fallback directions, the extreme coordinates and distances, a zero move,
// truncation toward zero on either sign, and margins that exceed the map.
// Six phases of random beats follow, each under its own register setting.
// Both stream sides stall at random, except for one steady stretch.
// ----------------------------------------------------------------------------
module retreat_point_from_danger_tb;
    import rpfd_pkg::*;

    localparam int CW          = COORD_BITS_DEF;
    localparam int S_W         = ((5 * CW + 7) / 8) * 8;
    localparam int M_W         = ((2 * CW + 7) / 8) * 8;
    // Time for one item: its computation plus taking the next beat.
    localparam int ITEM_CYCLES = 3 * CW + 5;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 100;

    // The packed layout matches the result tdata: away_x low, away_y high.
    typedef struct packed {
        logic [CW-1:0] y;
        logic [CW-1:0] x;
    } t_away;

    typedef enum logic {
        ROW_MOVE,
        ROW_WRITE
    } t_row_kind;

    // One line of the directed table: either a register write or a beat.
    // A beat with a typed result carries it in want; all others are predicted.
    typedef struct {
        t_row_kind     kind;
        t_reg_idx      reg_idx;
        logic [15:0]   reg_val;
        logic [CW-1:0] ox;
        logic [CW-1:0] oy;
        logic [CW-1:0] px;
        logic [CW-1:0] py;
        logic [CW-1:0] step_len;
        logic          typed;
        t_away         want;
    } t_plan_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    // origin_x, origin_y, danger_x, danger_y, step_distance (lowest first)
    logic [S_W-1:0]        i_s_tdata;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    // away_x, away_y (lowest first)
    logic [M_W-1:0]        o_m_tdata;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // The bench's own copy of the registers, updated on every write.
    logic [15:0] cfg_width      = RST_MAP_WIDTH;
    logic [15:0] cfg_height     = RST_MAP_HEIGHT;
    logic [15:0] cfg_margin     = RST_EDGE_MARGIN;
    logic        cfg_player_one = RST_PLAYER_ONE;

    t_away     pending_away[$];
    t_plan_row plan[$];
    int        mismatch_count = 0;
    // While set, neither side stalls.
    logic      steady = 1'b0;

    retreat_point_from_danger #(
        .COORD_BITS(CW)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Clamp one moved coordinate to [margin, max(margin, size - margin)].
    function automatic logic [CW-1:0] keep_on_map(input longint pos, input logic [15:0] size);
        longint lo;
        longint hi;
        lo = longint'({48'd0, cfg_margin});
        hi = longint'({48'd0, size}) - lo;
        if (hi < lo) begin
            hi = lo;
        end
        if (pos < lo) begin
            pos = lo;
        end
        if (pos > hi) begin
            pos = hi;
        end
        return pos[CW-1:0];
    endfunction

    // Expected retreat point for one beat under the current registers.
    function automatic t_away retreat_predict(input logic [CW-1:0] ox, input logic [CW-1:0] oy,
                                              input logic [CW-1:0] px, input logic [CW-1:0] py,
                                              input logic [CW-1:0] step_len);
        longint          dx;
        longint          dy;
        longint          len;
        longint          step;
        longint unsigned sq;
        longint unsigned root;
        longint unsigned trial;
        t_away           res;
        dx   = longint'({48'd0, ox}) - longint'({48'd0, px});
        dy   = longint'({48'd0, oy}) - longint'({48'd0, py});
        step = longint'({48'd0, step_len});
        sq   = longint'(dx * dx + dy * dy);
        // The square sum stays below 2^34, so the root fits in 18 bits.
        // Each root bit is kept if the square of the trial does not overshoot.
        root = 0;
        for (int b = 17; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= sq) begin
                root = trial;
            end
        end
        len = longint'(root);
        // Coincident points fall back to a unit step along the x axis.
        if (len == 0) begin
            dx  = cfg_player_one ? -64'sd1 : 64'sd1;
            dy  = 0;
            len = 1;
        end
        // Signed division here truncates toward zero, as the block does.
        res.x = keep_on_map(longint'({48'd0, ox}) + (dx * step) / len, cfg_width);
        res.y = keep_on_map(longint'({48'd0, oy}) + (dy * step) / len, cfg_height);
        return res;
    endfunction

    function automatic t_plan_row row_move(input logic [CW-1:0] ox, input logic [CW-1:0] oy,
                                           input logic [CW-1:0] px, input logic [CW-1:0] py,
                                           input logic [CW-1:0] step_len, input logic typed,
                                           input logic [CW-1:0] ex, input logic [CW-1:0] ey);
        t_plan_row r;
        r.kind     = ROW_MOVE;
        r.reg_idx  = REG_MAP_WIDTH;
        r.reg_val  = '0;
        r.ox       = ox;
        r.oy       = oy;
        r.px       = px;
        r.py       = py;
        r.step_len = step_len;
        r.typed    = typed;
        r.want.x   = ex;
        r.want.y   = ey;
        return r;
    endfunction

    function automatic t_plan_row row_reg(input t_reg_idx idx, input logic [15:0] val);
        t_plan_row r;
        r         = row_move('0, '0, '0, '0, '0, 1'b0, '0, '0);
        r.kind    = ROW_WRITE;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // Append one line to the directed table.
    function automatic void plan_add(input t_plan_row entry);
        plan = {plan, entry};
    endfunction

    // Map extents for the random phases: the extremes now and then,
    // otherwise a map large enough that most moves stay on it.
    function automatic logic [15:0] pick_extent();
        case ($urandom_range(5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(65535));
            default: return 16'($urandom_range(65535, 1000));
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Registers are only written once every pending result has come back.
    // Since each beat yields exactly one result, the block is idle then.
    task automatic write_reg(input t_reg_idx idx, input logic [15:0] val);
        i_s_tvalid = 1'b0;
        while (pending_away.size() != 0) begin
            @(negedge i_clk);
        end
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        case (idx)
            REG_MAP_WIDTH:   cfg_width      = val;
            REG_MAP_HEIGHT:  cfg_height     = val;
            REG_EDGE_MARGIN: cfg_margin     = val;
            REG_PLAYER_ONE:  cfg_player_one = val[0];
            default: ;
        endcase
    endtask

    // Offer one input beat, stalling at random first, and record what its
    // result must be once the beat is taken.
    task automatic push_move(input logic [CW-1:0] ox, input logic [CW-1:0] oy,
                             input logic [CW-1:0] px, input logic [CW-1:0] py,
                             input logic [CW-1:0] step_len, input logic typed,
                             input t_away want);
        while (!steady && $urandom_range(99) < 11) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = {step_len, py, px, oy, ox};
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
        pending_away = {pending_away,
                        (typed ? want : retreat_predict(ox, oy, px, py, step_len))};
        @(negedge i_clk);
    endtask

    // The result side stalls on its own random schedule.
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            i_m_tready = steady || ($urandom_range(99) >= 11);
        end
    end

    // Every result beat is checked against the oldest pending prediction.
    always @(posedge i_clk) begin
        t_away got;
        t_away want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = o_m_tdata[2*CW-1:0];
            if (pending_away.size() == 0) begin
                flag_mismatch("result beat with nothing pending, away_x", got.x, -1);
            end else begin
                want = pending_away.pop_front();
                if (got.x !== want.x) begin
                    flag_mismatch("away_x", got.x, want.x);
                end
                if (got.y !== want.y) begin
                    flag_mismatch("away_y", got.y, want.y);
                end
            end
        end
    end

    initial begin
        logic [CW-1:0] ox;
        logic [CW-1:0] oy;
        logic [CW-1:0] px;
        logic [CW-1:0] py;
        logic [CW-1:0] step_len;
        int            item_no;

        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset values first: full map, no margin, fallback along -x.
        // Coincident points, then the far corners at full distance.
        plan_add(row_move(100, 100, 100, 100, 50, 1'b1, 50, 100));
        plan_add(row_move(0, 0, 0, 0, 16'hFFFF, 1'b1, 0, 0));
        plan_add(row_move(16'hFFFF, 16'hFFFF, 0, 0, 16'hFFFF, 1'b1, 16'hFFFF, 16'hFFFF));
        plan_add(row_move(0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 0, 0));
        // Axis-aligned moves, and a zero distance that leaves the point alone.
        plan_add(row_move(1000, 500, 0, 500, 300, 1'b1, 1300, 500));
        plan_add(row_move(1234, 4321, 7, 9, 0, 1'b1, 1234, 4321));
        plan_add(row_move(500, 1000, 500, 2000, 300, 1'b1, 500, 700));
        // Fractional steps truncate toward zero on both signs.
        plan_add(row_move(300, 400, 0, 0, 7, 1'b0, 0, 0));
        plan_add(row_move(300, 400, 600, 800, 7, 1'b0, 0, 0));
        // A unit length with the largest distance runs off either map edge.
        plan_add(row_move(10, 10, 11, 10, 16'hFFFF, 1'b1, 0, 10));
        plan_add(row_move(16'hFFFE, 0, 16'hFFFD, 0, 16'hFFFF, 1'b1, 16'hFFFF, 0));
        // Fallback along +x on a small map with a margin of 100.
        plan_add(row_reg(REG_PLAYER_ONE, 16'd0));
        plan_add(row_reg(REG_EDGE_MARGIN, 16'd100));
        plan_add(row_reg(REG_MAP_WIDTH, 16'd1000));
        plan_add(row_reg(REG_MAP_HEIGHT, 16'd2000));
        plan_add(row_move(500, 500, 500, 500, 50, 1'b1, 550, 500));
        plan_add(row_move(950, 500, 950, 500, 100, 1'b1, 900, 500));
        plan_add(row_move(0, 0, 0, 0, 0, 1'b1, 100, 100));
        plan_add(row_move(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 1'b1, 900, 1900));
        // A margin wider than half the map pins both axes to the margin.
        plan_add(row_reg(REG_EDGE_MARGIN, 16'd40000));
        plan_add(row_reg(REG_MAP_WIDTH, 16'hFFFF));
        plan_add(row_reg(REG_MAP_HEIGHT, 16'd0));
        plan_add(row_move(1, 2, 3, 4, 5, 1'b1, 40000, 40000));
        plan_add(row_move(16'hFFFF, 0, 0, 16'hFFFF, 16'hFFFF, 1'b1, 40000, 40000));
        // Largest margin with an empty map; only bit 0 of player_one counts.
        plan_add(row_reg(REG_EDGE_MARGIN, 16'hFFFF));
        plan_add(row_reg(REG_MAP_WIDTH, 16'd0));
        plan_add(row_reg(REG_MAP_HEIGHT, 16'hFFFF));
        plan_add(row_reg(REG_PLAYER_ONE, 16'hAAAB));
        plan_add(row_move(12345, 54321, 54321, 12345, 999, 1'b1, 16'hFFFF, 16'hFFFF));
        // An empty map with no margin collapses everything onto the origin.
        plan_add(row_reg(REG_EDGE_MARGIN, 16'd0));
        plan_add(row_reg(REG_MAP_WIDTH, 16'd0));
        plan_add(row_reg(REG_MAP_HEIGHT, 16'd0));
        plan_add(row_move(5, 5, 0, 0, 10, 1'b1, 0, 0));
        // The upper bits of a player_one write must not select -x.
        plan_add(row_reg(REG_MAP_WIDTH, 16'hFFFF));
        plan_add(row_reg(REG_MAP_HEIGHT, 16'hFFFF));
        plan_add(row_reg(REG_PLAYER_ONE, 16'h0002));
        plan_add(row_move(7, 7, 7, 7, 3, 1'b1, 10, 7));

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                push_move(plan[i].ox, plan[i].oy, plan[i].px, plan[i].py, plan[i].step_len,
                          plan[i].typed, plan[i].want);
            end
        end

        // Random phases. Each one starts by rewriting every register, then
        // sends beats whose danger point is either right on top of the
        // origin, nearby, or anywhere at all, so short vectors, where
        // rounding and the fallback matter most, are well represented.
        item_no = 0;
        for (int phase = 0; phase < PHASES; phase++) begin
            write_reg(REG_MAP_WIDTH, pick_extent());
            write_reg(REG_MAP_HEIGHT, pick_extent());
            case ($urandom_range(9))
                0:       write_reg(REG_EDGE_MARGIN, 16'd0);
                1:       write_reg(REG_EDGE_MARGIN, 16'hFFFF);
                2:       write_reg(REG_EDGE_MARGIN, 16'($urandom_range(65535)));
                default: write_reg(REG_EDGE_MARGIN, 16'($urandom_range(300)));
            endcase
            write_reg(REG_PLAYER_ONE, 16'($urandom_range(65535)));

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // One long stretch with no stalls on either side.
                steady = (item_no >= 250) && (item_no < 350);
                ox = CW'($urandom_range(65535));
                oy = CW'($urandom_range(65535));
                case ($urandom_range(9))
                    0, 1: begin
                        px = ox + CW'($urandom_range(6)) - CW'(3);
                        py = oy + CW'($urandom_range(6)) - CW'(3);
                    end
                    2, 3, 4: begin
                        px = ox + CW'($urandom_range(4000)) - CW'(2000);
                        py = oy + CW'($urandom_range(4000)) - CW'(2000);
                    end
                    default: begin
                        px = CW'($urandom_range(65535));
                        py = CW'($urandom_range(65535));
                    end
                endcase
                if ($urandom_range(2) == 0) begin
                    step_len = CW'($urandom_range(65535));
                end else begin
                    step_len = CW'($urandom_range(2000));
                end
                push_move(ox, oy, px, py, step_len, 1'b0, '0);
                item_no++;
            end
        end
        steady     = 1'b0;
        i_s_tvalid = 1'b0;

        // Drain, then give the block one more item time to show any stray beat.
        while (pending_away.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (ITEM_CYCLES + 10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[retreat_point_from_danger] OK");
        end else begin
            $display("[retreat_point_from_danger] ERROR");
        end
        $finish;
    end

    // Ends a hung run with an error, well after a correct run would finish.
    initial begin
        #2_000_000;
        $display("[retreat_point_from_danger] ERROR");
        $finish;
    end

endmodule
